[rtl/sosc_pkg.sv]
// shared constants for the segmented odd-only prime sieve counter
package sosc_pkg;

    localparam int BLOCK_SIZE_DEF = 131072;
    localparam int VALUE_BITS_DEF = 30;
    localparam int RANGE_W        = 30;
    localparam int COUNT_W        = 17;

endpackage

[rtl/segmented_odd_prime_sieve_count.sv]
// top level: segmented odd-only sieve that counts the primes of one segment
//
// A request gives an even range_start and an inclusive range_end, and one result returns
// the number of primes in that segment, or range_error for an odd start, an end below the
// start or an end more than BLOCK_SIZE above the start. A request is worked one at a time
// through a single-port bitmap of one bit per odd value and one bit-serial remainder unit.
// A rejected request goes from S_IDLE to S_DONE and then into the output register.
// For an accepted one, S = (end - start + 1) / 2 bitmap slots are filled, then counted;
// for each of the P odd p >= 3 with p*p <= end, start mod p is found one bit at a time and
// the M odd multiples are cleared, one bitmap write per cycle. The bitmap is fully
// written before it is read, so no clearing pass follows reset. in_stall stays high
// while a request is in progress; a finished result waits in the output register until
// it is taken.
module segmented_odd_prime_sieve_count #(
    parameter int BLOCK_SIZE = sosc_pkg::BLOCK_SIZE_DEF,
    parameter int VALUE_BITS = sosc_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sosc_pkg::RANGE_W-1:0] range_start,
    input  logic [sosc_pkg::RANGE_W-1:0] range_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sosc_pkg::COUNT_W-1:0] prime_count,
    output logic                         range_error
);
    import sosc_pkg::*;

    localparam int ODD_DEPTH = BLOCK_SIZE / 2 + 1;
    localparam int ADDR_W    = $clog2(ODD_DEPTH);
    localparam int SLOT_W    = $clog2(ODD_DEPTH + 1);
    localparam int TOT_W     = $clog2(ODD_DEPTH + 2);
    localparam int VW        = VALUE_BITS + 1;
    localparam int P_W       = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_W      = 2 * P_W;
    localparam int BIT_W     = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_SQ,
        S_CHK,
        S_DIV,
        S_FIRST,
        S_MARK,
        S_CNT,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   lo_reg, lo_next;
    logic [VALUE_BITS-1:0]   hi_reg, hi_next;
    logic [SLOT_W-1:0]       slots_reg, slots_next;
    logic [SLOT_W-1:0]       k_reg, k_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [P_W-1:0]          rem_reg, rem_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [VW-1:0]           v_reg, v_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic                    err_reg, err_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]      prime_count_reg, prime_count_next;
    logic                    range_error_reg, range_error_next;

    logic                    odd_bitmap [ODD_DEPTH];
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_wdata;
    logic                    mem_rd_reg;

    // bitmap, one access per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            odd_bitmap[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= odd_bitmap[mem_addr];
    end

    always_comb
    begin
        logic [VALUE_BITS-1:0] lo_in;
        logic [VALUE_BITS-1:0] hi_in;
        logic [VALUE_BITS-1:0] diff;
        logic                  bad;
        logic [P_W:0]          shifted;
        logic [P_W-1:0]        adj;
        logic [VW-1:0]         cand;
        logic [VW-1:0]         sqv;

        lo_in    = range_start[VALUE_BITS-1:0];
        hi_in    = range_end[VALUE_BITS-1:0];
        diff     = hi_in - lo_in;
        bad      = lo_in[0] || (hi_in < lo_in) || (32'(diff) > 32'(BLOCK_SIZE));
        shifted  = {rem_reg, lo_reg[bit_reg]};
        adj      = (rem_reg == '0) ? '0 : p_reg - rem_reg;
        cand     = VW'(lo_reg) + VW'(adj);
        sqv      = VW'(sq_reg);

        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        slots_next       = slots_reg;
        k_next           = k_reg;
        p_next           = p_reg;
        sq_next          = sq_reg;
        rem_next         = rem_reg;
        bit_next         = bit_reg;
        v_next           = v_reg;
        total_next       = total_reg;
        err_next         = err_reg;
        rd_vld_next      = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        prime_count_next = prime_count_reg;
        range_error_next = range_error_reg;
        mem_we           = 1'b0;
        mem_addr         = k_reg[ADDR_W-1:0];
        mem_wdata        = 1'b0;

        // count survivors of the read issued last cycle
        if (rd_vld_reg)
        begin
            total_next = total_reg + TOT_W'(mem_rd_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next    = lo_in;
                    hi_next    = hi_in;
                    err_next   = bad;
                    k_next     = '0;
                    slots_next = SLOT_W'((32'(diff) + 32'd1) >> 1);
                    state_next = bad ? S_DONE : S_FILL;
                end
            end
            S_FILL:
            begin
                if (k_reg < slots_reg)
                begin
                    // value 1 is not prime
                    mem_we    = 1'b1;
                    mem_wdata = !((lo_reg == '0) && (k_reg == '0));
                    k_next    = k_reg + SLOT_W'(1);
                end
                else
                begin
                    p_next     = P_W'(3);
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sq_next    = SQ_W'(p_reg) * SQ_W'(p_reg);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sq_reg > SQ_W'(hi_reg))
                begin
                    k_next     = '0;
                    total_next = ((lo_reg <= VALUE_BITS'(2)) && (hi_reg >= VALUE_BITS'(2)))
                                 ? TOT_W'(1) : '0;
                    state_next = S_CNT;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_W'(VALUE_BITS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring remainder, one bit of start per cycle
                if (shifted >= (P_W + 1)'(p_reg))
                begin
                    rem_next = P_W'(shifted - (P_W + 1)'(p_reg));
                end
                else
                begin
                    rem_next = P_W'(shifted);
                end
                if (bit_reg == '0)
                begin
                    state_next = S_FIRST;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            S_FIRST:
            begin
                if (cand < sqv)
                begin
                    cand = sqv;
                end
                v_next     = cand[0] ? cand : cand + VW'(p_reg);
                state_next = S_MARK;
            end
            S_MARK:
            begin
                if (v_reg <= VW'(hi_reg))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    mem_addr  = ADDR_W'((v_reg - VW'(lo_reg)) >> 1);
                    v_next    = v_reg + (VW'(p_reg) << 1);
                end
                else
                begin
                    p_next     = p_reg + P_W'(2);
                    state_next = S_SQ;
                end
            end
            S_CNT:
            begin
                if (k_reg < slots_reg)
                begin
                    rd_vld_next = 1'b1;
                    k_next      = k_reg + SLOT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    prime_count_next = err_reg ? '0 : COUNT_W'(total_reg);
                    range_error_next = err_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_vld_reg      <= rd_vld_next;
            out_valid_reg   <= out_valid_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            slots_reg       <= slots_next;
            k_reg           <= k_next;
            p_reg           <= p_next;
            sq_reg          <= sq_next;
            rem_reg         <= rem_next;
            bit_reg         <= bit_next;
            v_reg           <= v_next;
            total_reg       <= total_next;
            err_reg         <= err_next;
            prime_count_reg <= prime_count_next;
            range_error_reg <= range_error_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign prime_count = prime_count_reg;
    assign range_error = range_error_reg;

endmodule

[rtl/sosc_checker.sv]
// port-level checks for the segmented odd-only prime sieve counter
module sosc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [sosc_pkg::RANGE_W-1:0] range_start,
    input  logic [sosc_pkg::RANGE_W-1:0] range_end,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [sosc_pkg::COUNT_W-1:0] prime_count,
    input  logic                         range_error
);
    import sosc_pkg::*;

    // a rejected request never reports primes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (prime_count == '0))
        else $error("rejected request with nonzero count");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while another is in progress");

    // an odd start is always rejected, and the result cannot come in the next cycle
    a_odd_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && range_start[0] && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(prime_count) && $stable(range_error)))
        else $error("stalled result changed");

endmodule

bind segmented_odd_prime_sieve_count sosc_checker u_sosc_checker (.*);
